// ===== design/msgve_pkg.sv =====
`timescale 1ns / 1ps

package msgve_pkg;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [3:0] {
    KIND_NIL    = 4'd0,
    KIND_BOOL   = 4'd1,
    KIND_UINT   = 4'd2,
    KIND_INT    = 4'd3,
    KIND_STR    = 4'd4,
    KIND_BIN    = 4'd5,
    KIND_ARRAY  = 4'd6,
    KIND_MAP    = 4'd7,
    KIND_DOUBLE = 4'd8,
    KIND_RAW    = 4'd9
  } kind_t;

  localparam logic [7:0] HDR_NIL      = 8'hc0;
  localparam logic [7:0] HDR_FALSE    = 8'hc2;
  localparam logic [7:0] HDR_TRUE     = 8'hc3;
  localparam logic [7:0] HDR_BIN8     = 8'hc4;
  localparam logic [7:0] HDR_BIN16    = 8'hc5;
  localparam logic [7:0] HDR_BIN32    = 8'hc6;
  localparam logic [7:0] HDR_FLOAT64  = 8'hcb;
  localparam logic [7:0] HDR_UINT8    = 8'hcc;
  localparam logic [7:0] HDR_UINT16   = 8'hcd;
  localparam logic [7:0] HDR_UINT32   = 8'hce;
  localparam logic [7:0] HDR_UINT64   = 8'hcf;
  localparam logic [7:0] HDR_INT8     = 8'hd0;
  localparam logic [7:0] HDR_INT16    = 8'hd1;
  localparam logic [7:0] HDR_INT32    = 8'hd2;
  localparam logic [7:0] HDR_INT64    = 8'hd3;
  localparam logic [7:0] HDR_FIXSTR   = 8'ha0;
  localparam logic [7:0] HDR_STR8     = 8'hd9;
  localparam logic [7:0] HDR_STR16    = 8'hda;
  localparam logic [7:0] HDR_STR32    = 8'hdb;
  localparam logic [7:0] HDR_FIXARRAY = 8'h90;
  localparam logic [7:0] HDR_ARRAY16  = 8'hdc;
  localparam logic [7:0] HDR_ARRAY32  = 8'hdd;
  localparam logic [7:0] HDR_FIXMAP   = 8'h80;
  localparam logic [7:0] HDR_MAP16    = 8'hde;
  localparam logic [7:0] HDR_MAP32    = 8'hdf;

  // payload is left-aligned: first byte to send sits in bits 63:56
  typedef struct packed {
    logic [7:0]  head;
    logic [63:0] payload;
    logic [3:0]  nbytes;
  } entry_t;

endpackage

// ===== design/msgve_front.sv =====
`timescale 1ns / 1ps

module msgve_front (
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [3:0]            in_kind,
  input  logic [63:0]           in_value,
  input  logic [31:0]           in_length,
  input  logic                  q_full,
  output logic                  q_push,
  output msgve_pkg::entry_t     q_entry
);

  logic [63:0] v;
  logic [31:0] n;
  logic        defined;

  assign v = in_value;
  assign n = in_length;

  function automatic msgve_pkg::entry_t mk(input logic [7:0] head, input logic [63:0] pl,
                                           input logic [3:0] nb);
    msgve_pkg::entry_t e;
    e.head    = head;
    e.payload = pl;
    e.nbytes  = nb;
    return e;
  endfunction

  function automatic msgve_pkg::entry_t enc_uint(input logic [63:0] x);
    msgve_pkg::entry_t e;
    if (x <= 64'h7f) begin
      e = mk(x[7:0], 64'd0, 4'd0);
    end else if (x <= 64'hff) begin
      e = mk(msgve_pkg::HDR_UINT8, {x[7:0], 56'd0}, 4'd1);
    end else if (x <= 64'hffff) begin
      e = mk(msgve_pkg::HDR_UINT16, {x[15:0], 48'd0}, 4'd2);
    end else if (x <= 64'hffff_ffff) begin
      e = mk(msgve_pkg::HDR_UINT32, {x[31:0], 32'd0}, 4'd4);
    end else begin
      e = mk(msgve_pkg::HDR_UINT64, x, 4'd8);
    end
    return e;
  endfunction

  function automatic msgve_pkg::entry_t enc_count(input logic [31:0] c,
                                                  input logic [7:0] fixbase,
                                                  input logic [7:0] h16,
                                                  input logic [7:0] h32);
    msgve_pkg::entry_t e;
    if (c <= 32'd15) begin
      e = mk(fixbase | {4'd0, c[3:0]}, 64'd0, 4'd0);
    end else if (c <= 32'hffff) begin
      e = mk(h16, {c[15:0], 48'd0}, 4'd2);
    end else begin
      e = mk(h32, {c, 32'd0}, 4'd4);
    end
    return e;
  endfunction

  always_comb begin
    defined = 1'b1;
    q_entry = mk(msgve_pkg::HDR_NIL, 64'd0, 4'd0);
    case (msgve_pkg::kind_t'(in_kind))
      msgve_pkg::KIND_NIL: begin
        q_entry = mk(msgve_pkg::HDR_NIL, 64'd0, 4'd0);
      end
      msgve_pkg::KIND_BOOL: begin
        q_entry = mk(v[0] ? msgve_pkg::HDR_TRUE : msgve_pkg::HDR_FALSE, 64'd0, 4'd0);
      end
      msgve_pkg::KIND_UINT: begin
        q_entry = enc_uint(v);
      end
      msgve_pkg::KIND_INT: begin
        if (!v[63]) begin
          q_entry = enc_uint(v);
        end else if (v >= 64'hffff_ffff_ffff_ffe0) begin
          q_entry = mk(v[7:0], 64'd0, 4'd0);
        end else if (v >= 64'hffff_ffff_ffff_ff80) begin
          q_entry = mk(msgve_pkg::HDR_INT8, {v[7:0], 56'd0}, 4'd1);
        end else if (v >= 64'hffff_ffff_ffff_8000) begin
          q_entry = mk(msgve_pkg::HDR_INT16, {v[15:0], 48'd0}, 4'd2);
        end else if (v >= 64'hffff_ffff_8000_0000) begin
          q_entry = mk(msgve_pkg::HDR_INT32, {v[31:0], 32'd0}, 4'd4);
        end else begin
          q_entry = mk(msgve_pkg::HDR_INT64, v, 4'd8);
        end
      end
      msgve_pkg::KIND_STR: begin
        if (n <= 32'd31) begin
          q_entry = mk(msgve_pkg::HDR_FIXSTR | {3'd0, n[4:0]}, 64'd0, 4'd0);
        end else if (n <= 32'hff) begin
          q_entry = mk(msgve_pkg::HDR_STR8, {n[7:0], 56'd0}, 4'd1);
        end else if (n <= 32'hffff) begin
          q_entry = mk(msgve_pkg::HDR_STR16, {n[15:0], 48'd0}, 4'd2);
        end else begin
          q_entry = mk(msgve_pkg::HDR_STR32, {n, 32'd0}, 4'd4);
        end
      end
      msgve_pkg::KIND_BIN: begin
        if (n <= 32'hff) begin
          q_entry = mk(msgve_pkg::HDR_BIN8, {n[7:0], 56'd0}, 4'd1);
        end else if (n <= 32'hffff) begin
          q_entry = mk(msgve_pkg::HDR_BIN16, {n[15:0], 48'd0}, 4'd2);
        end else begin
          q_entry = mk(msgve_pkg::HDR_BIN32, {n, 32'd0}, 4'd4);
        end
      end
      msgve_pkg::KIND_ARRAY: begin
        q_entry = enc_count(n, msgve_pkg::HDR_FIXARRAY, msgve_pkg::HDR_ARRAY16,
                            msgve_pkg::HDR_ARRAY32);
      end
      msgve_pkg::KIND_MAP: begin
        q_entry = enc_count(n, msgve_pkg::HDR_FIXMAP, msgve_pkg::HDR_MAP16,
                            msgve_pkg::HDR_MAP32);
      end
      msgve_pkg::KIND_DOUBLE: begin
        q_entry = mk(msgve_pkg::HDR_FLOAT64, v, 4'd8);
      end
      msgve_pkg::KIND_RAW: begin
        q_entry = mk(v[7:0], 64'd0, 4'd0);
      end
      default: begin
        defined = 1'b0;
      end
    endcase
  end

  // drop undefined kinds without touching the queue
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && defined;

endmodule

// ===== design/msgve_fifo.sv =====
`timescale 1ns / 1ps

module msgve_fifo #(
  parameter int DEPTH = msgve_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  msgve_pkg::entry_t wr_entry,
  input  logic              pop,
  output msgve_pkg::entry_t rd_entry,
  output logic              full,
  output logic              empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  msgve_pkg::entry_t mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign rd_entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

endmodule

// ===== design/msgve_back.sv =====
`timescale 1ns / 1ps

module msgve_back (
  input  logic              clk,
  input  logic              rst_n,
  input  msgve_pkg::entry_t q_entry,
  input  logic              q_empty,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_byte,
  output logic              out_last_byte
);

  logic        busy_r, busy_nxt;
  logic [63:0] shreg_r, shreg_nxt;
  logic [3:0]  remain_r, remain_nxt;
  logic        valid_r, valid_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        last_r, last_nxt;
  logic        advance;

  assign advance = !valid_r || !out_stall;

  always_comb begin
    busy_nxt   = busy_r;
    shreg_nxt  = shreg_r;
    remain_nxt = remain_r;
    valid_nxt  = valid_r;
    byte_nxt   = byte_r;
    last_nxt   = last_r;
    q_pop      = 1'b0;
    if (advance) begin
      if (busy_r) begin
        valid_nxt  = 1'b1;
        byte_nxt   = shreg_r[63:56];
        last_nxt   = (remain_r == 4'd1);
        busy_nxt   = (remain_r != 4'd1);
        remain_nxt = remain_r - 4'd1;
        shreg_nxt  = {shreg_r[55:0], 8'd0};
      end else if (!q_empty) begin
        q_pop      = 1'b1;
        valid_nxt  = 1'b1;
        byte_nxt   = q_entry.head;
        last_nxt   = (q_entry.nbytes == 4'd0);
        busy_nxt   = (q_entry.nbytes != 4'd0);
        remain_nxt = q_entry.nbytes;
        shreg_nxt  = q_entry.payload;
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      valid_r  <= 1'b0;
      remain_r <= 4'd0;
    end else begin
      busy_r   <= busy_nxt;
      valid_r  <= valid_nxt;
      remain_r <= remain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shreg_r <= shreg_nxt;
    byte_r  <= byte_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid     = valid_r;
  assign out_byte      = byte_r;
  assign out_last_byte = last_r;

endmodule

// ===== design/msgpack_value_encoder_top.sv =====
`timescale 1ns / 1ps

// MessagePack value encoder. Each input item carries one typed value (kind, value, length)
// and comes out as its MessagePack encoding, one byte per output item, most significant
// byte first, with out_last_byte set on the final byte. An item's encoding is one to nine
// bytes long; the byte serialiser in the back end sends one byte per cycle while out_stall
// is low, with no gap between items while the queue holds the next one. The front end
// classifies a value in the cycle it is accepted and parks it in a small queue
// (QUEUE_DEPTH entries), so input is taken while earlier encodings are still draining.
// Undefined kinds are accepted and produce no output.
module msgpack_value_encoder_top #(
  parameter int QUEUE_DEPTH = msgve_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_kind,
  input  logic [63:0] in_value,
  input  logic [31:0] in_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last_byte
);

  msgve_pkg::entry_t wr_entry;
  msgve_pkg::entry_t rd_entry;
  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_empty;

  msgve_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_kind   (in_kind),
    .in_value  (in_value),
    .in_length (in_length),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (wr_entry)
  );

  msgve_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_entry (wr_entry),
    .pop      (q_pop),
    .rd_entry (rd_entry),
    .full     (q_full),
    .empty    (q_empty)
  );

  msgve_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_entry       (rd_entry),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_last_byte (out_last_byte)
  );

endmodule
